FILE: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/flbr_pkg.sv
// types and constants for the free list bitmap rebuild block
package flbr_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int BIT_POS_W  = 6;

   localparam logic [31:0] END_LINK = 32'hFFFF_FFFF;
   localparam logic [31:0] MAX_LINK = 32'h7FFF_FFFF;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_RUN  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_FAIL,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic load_link;
      logic start_run;
      logic init_write;
      logic walk_read;
      logic walk_update;
      logic emit_read;
      logic out_load_word;
      logic out_load_fail;
      logic emit_next;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hdr_ok;
      logic init_last;
      logic walk_end;
      logic step_fail;
      logic next_end;
      logic final_ok;
      logic out_taken;
      logic out_last;
   } dp_status_type;

endpackage

FILE: rtl/flbr_if.sv
// request and response channel interfaces
interface flbr_req_if import flbr_pkg::*; ();
   logic               valid;
   logic               ready;
   cmd_type            command;
   logic        [7:0]  slot_index;
   logic        [31:0] link_word;
   logic signed [31:0] first_free;
   logic signed [31:0] active_count;

   modport source (output valid, command, slot_index, link_word, first_free, active_count,
                   input ready);
   modport sink   (input valid, command, slot_index, link_word, first_free, active_count,
                   output ready);
endinterface

interface flbr_rsp_if ();
   logic        valid;
   logic        ready;
   logic        ok;
   logic [8:0]  allocated_count;
   logic [1:0]  word_index;
   logic [63:0] bitmap_word;
   logic        last;

   modport source (output valid, ok, allocated_count, word_index, bitmap_word, last,
                   input ready);
   modport sink   (input valid, ok, allocated_count, word_index, bitmap_word, last,
                   output ready);
endinterface

FILE: rtl/flbr_ctrl.sv
// controller state machine for the free list rebuild
module flbr_ctrl import flbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  cmd_type       req_command,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_command == CMD_RUN) begin
               state_in = status.hdr_ok ? ST_INIT : ST_FAIL;
            end
         end
         ST_INIT: begin
            if (status.init_last) begin
               state_in = status.walk_end ? ST_EMIT_RD : ST_READ;
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.step_fail) begin
               state_in = ST_FAIL;
            end else if (status.next_end) begin
               state_in = status.final_ok ? ST_EMIT_RD : ST_FAIL;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: state_in = ST_WAIT;
         ST_FAIL:    state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.out_taken) begin
               state_in = status.out_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load_link = req_valid && req_command == CMD_LOAD;
            cmd.start_run = req_valid && req_command == CMD_RUN;
         end
         ST_INIT:    cmd.init_write = 1'b1;
         ST_READ:    cmd.walk_read = 1'b1;
         ST_CHECK:   cmd.walk_update = !status.step_fail;
         ST_EMIT_RD: cmd.emit_read = 1'b1;
         ST_EMIT_LD: cmd.out_load_word = 1'b1;
         ST_FAIL:    cmd.out_load_fail = 1'b1;
         ST_WAIT:    cmd.emit_next = status.out_taken && !status.out_last;
         default:    cmd = '0;
      endcase
   end

endmodule

FILE: rtl/flbr_dpath.sv
// datapath: link memory, bitmap memory, walk registers and result register
module flbr_dpath import flbr_pkg::*; #(
   parameter int POOL_SLOTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  logic        [7:0]  slot_index,
   input  logic        [31:0] link_word,
   input  logic signed [31:0] first_free,
   input  logic signed [31:0] active_count,
   input  logic               out_ready,
   output dp_status_type      status,
   output logic               out_valid,
   output logic               out_ok,
   output logic        [8:0]  out_count,
   output logic        [1:0]  out_word_index,
   output logic        [63:0] out_word,
   output logic               out_last
);

   localparam int SLOT_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
   localparam int NUM_WORDS = (POOL_SLOTS + WORD_WIDTH - 1) / WORD_WIDTH;
   localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int TAIL_BITS = POOL_SLOTS % WORD_WIDTH;
   localparam logic [WORD_WIDTH-1:0] TAIL_MASK =
      (TAIL_BITS == 0) ? {WORD_WIDTH{1'b1}} : ((64'd1 << TAIL_BITS) - 64'd1);

   logic [31:0]           link_mem [POOL_SLOTS];
   logic [WORD_WIDTH-1:0] bm_mem   [NUM_WORDS];

   logic [31:0]           link_rdata_ff;
   logic [WORD_WIDTH-1:0] bm_rdata_ff;

   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic              walk_end_ff, walk_end_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]  ac_ff, ac_in;
   logic [WIDX_W-1:0] init_idx_ff, init_idx_in;
   logic [WIDX_W-1:0] emit_idx_ff, emit_idx_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_ok_ff, out_ok_in;
   logic [8:0]            out_count_ff, out_count_in;
   logic [1:0]            out_widx_ff, out_widx_in;
   logic [WORD_WIDTH-1:0] out_word_ff, out_word_in;
   logic                  out_last_ff, out_last_in;

   logic [SLOT_W+BIT_POS_W-1:0] ptr_ext;
   logic [BIT_POS_W-1:0]        bit_pos;
   logic [WIDX_W-1:0]           word_sel;
   logic [WORD_WIDTH-1:0]       bit_mask;
   logic [WORD_WIDTH-1:0]       init_fill;
   logic                        slot_in_range;
   logic                        link_is_end, link_too_big, link_out_range, link_self;
   logic                        init_last, emit_last, out_taken;
   logic                        ac_ok, ff_is_end, ff_ok;

   // split the walk pointer into bitmap word and bit position
   assign ptr_ext  = {{BIT_POS_W{1'b0}}, ptr_ff};
   assign bit_pos  = ptr_ext[BIT_POS_W-1:0];
   assign word_sel = ptr_ext[WIDX_W+BIT_POS_W-1:BIT_POS_W];
   assign bit_mask = 64'd1 << bit_pos;

   assign init_last = init_idx_ff == WIDX_W'(NUM_WORDS - 1);
   assign emit_last = emit_idx_ff == WIDX_W'(NUM_WORDS - 1);
   assign init_fill = init_last ? TAIL_MASK : {WORD_WIDTH{1'b1}};
   assign out_taken = out_valid_ff && out_ready;

   // link memory: load port and walk read port
   assign slot_in_range = 32'(slot_index) < 32'(POOL_SLOTS);

   always_ff @(posedge clock) begin
      if (cmd.load_link && slot_in_range) begin
         link_mem[SLOT_W'(slot_index)] <= link_word;
      end
      if (cmd.walk_read) begin
         link_rdata_ff <= link_mem[ptr_ff];
      end
   end

   // bitmap memory: fill or clear-bit write, walk or emit read
   always_ff @(posedge clock) begin
      if (cmd.init_write) begin
         bm_mem[init_idx_ff] <= init_fill;
      end else if (cmd.walk_update) begin
         bm_mem[word_sel] <= bm_rdata_ff & ~bit_mask;
      end
      if (cmd.walk_read) begin
         bm_rdata_ff <= bm_mem[word_sel];
      end else if (cmd.emit_read) begin
         bm_rdata_ff <= bm_mem[emit_idx_ff];
      end
   end

   // header check
   assign ff_is_end = first_free == -32'sd1;
   assign ac_ok     = active_count >= 32'sd0 && active_count <= $signed(32'(POOL_SLOTS));
   assign ff_ok     = ff_is_end || (first_free >= 32'sd0 &&
                                    first_free < $signed(32'(POOL_SLOTS)));

   // link word classification
   assign link_is_end    = link_rdata_ff == END_LINK;
   assign link_too_big   = !link_is_end && link_rdata_ff > MAX_LINK;
   assign link_out_range = !link_is_end && link_rdata_ff >= 32'(POOL_SLOTS);
   assign link_self      = link_rdata_ff == 32'(ptr_ff);

   always_comb begin
      status.hdr_ok    = ac_ok && ff_ok &&
                         ((active_count == $signed(32'(POOL_SLOTS))) == ff_is_end);
      status.init_last = init_last;
      status.walk_end  = walk_end_ff;
      status.step_fail = steps_ff >= CNT_W'(POOL_SLOTS) || !bm_rdata_ff[bit_pos] ||
                         link_too_big || link_out_range || link_self;
      status.next_end  = link_is_end;
      status.final_ok  = (count_ff - 1'b1) == ac_ff;
      status.out_taken = out_taken;
      status.out_last  = out_last_ff;
   end

   // walk registers
   always_comb begin
      ptr_in      = ptr_ff;
      walk_end_in = walk_end_ff;
      count_in    = count_ff;
      steps_in    = steps_ff;
      ac_in       = ac_ff;
      init_idx_in = init_idx_ff;
      emit_idx_in = emit_idx_ff;
      if (cmd.start_run) begin
         ptr_in      = SLOT_W'(first_free);
         walk_end_in = ff_is_end;
         count_in    = CNT_W'(POOL_SLOTS);
         steps_in    = '0;
         ac_in       = active_count[CNT_W-1:0];
         init_idx_in = '0;
         emit_idx_in = '0;
      end
      if (cmd.init_write) begin
         init_idx_in = init_idx_ff + 1'b1;
      end
      if (cmd.walk_update) begin
         ptr_in      = link_rdata_ff[SLOT_W-1:0];
         walk_end_in = link_is_end;
         count_in    = count_ff - 1'b1;
         steps_in    = steps_ff + 1'b1;
      end
      if (cmd.emit_next) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_count_in = out_count_ff;
      out_widx_in  = out_widx_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_load_word) begin
         out_valid_in = 1'b1;
         out_ok_in    = 1'b1;
         out_count_in = 9'(count_ff);
         out_widx_in  = 2'(emit_idx_ff);
         out_word_in  = bm_rdata_ff;
         out_last_in  = emit_last;
      end else if (cmd.out_load_fail) begin
         out_valid_in = 1'b1;
         out_ok_in    = 1'b0;
         out_count_in = '0;
         out_widx_in  = '0;
         out_word_in  = '0;
         out_last_in  = 1'b1;
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      ptr_ff       <= ptr_in;
      walk_end_ff  <= walk_end_in;
      count_ff     <= count_in;
      steps_ff     <= steps_in;
      ac_ff        <= ac_in;
      init_idx_ff  <= init_idx_in;
      emit_idx_ff  <= emit_idx_in;
      out_ok_ff    <= out_ok_in;
      out_count_ff <= out_count_in;
      out_widx_ff  <= out_widx_in;
      out_word_ff  <= out_word_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid      = out_valid_ff;
   assign out_ok         = out_ok_ff;
   assign out_count      = out_count_ff;
   assign out_word_index = out_widx_ff;
   assign out_word       = out_word_ff;
   assign out_last       = out_last_ff;

endmodule

FILE: rtl/free_list_bitmap_rebuild_top.sv
// Free list bitmap rebuild: load transfers store one 32-bit link word per slot in
// the link memory, one per cycle while idle. A run transfer checks the header in its
// accept cycle, fills the bitmap memory with all-allocated words (one word a cycle),
// then walks the free list, for each free slot one registered read of the link and
// bitmap memories, then the checks and the clear-bit write-back. A successful run
// then sends one result per bitmap word: a registered read of the word, a load of
// the result register, then a wait until rsp_chan.ready takes it before the next
// word is read. A failing run sends one result with ok clear. No new transfer is
// taken until the run's last result has gone. Every slot the walk can reach must
// have been loaded beforehand.
module free_list_bitmap_rebuild_top import flbr_pkg::*; #(
   parameter int POOL_SLOTS = 256
) (
   input  logic clock,
   input  logic reset,
   flbr_req_if.sink   req_chan,
   flbr_rsp_if.source rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller
   flbr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath
   flbr_dpath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .slot_index     (req_chan.slot_index),
      .link_word      (req_chan.link_word),
      .first_free     (req_chan.first_free),
      .active_count   (req_chan.active_count),
      .out_ready      (rsp_chan.ready),
      .status         (status),
      .out_valid      (rsp_chan.valid),
      .out_ok         (rsp_chan.ok),
      .out_count      (rsp_chan.allocated_count),
      .out_word_index (rsp_chan.word_index),
      .out_word       (rsp_chan.bitmap_word),
      .out_last       (rsp_chan.last)
   );

   assign req_chan.ready = cmd.req_ready;

endmodule

FILE: rtl/flbr_checker.sv
// port-level checker for the free list rebuild, bound to the top level
`include "assert_macros.svh"

module flbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [8:0]  rsp_allocated_count,
   input logic [1:0]  rsp_word_index,
   input logic [63:0] rsp_bitmap_word,
   input logic        rsp_last
);

   logic load_xfer;

   assign load_xfer = req_valid && req_ready && !req_command;

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // a failure result is a single cleared result that closes the run
   `ASSERT_IMPLY(a_fail_shape, clock, reset, rsp_valid && !rsp_ok, rsp_last && rsp_bitmap_word == 64'd0 && rsp_allocated_count == 9'd0 && rsp_word_index == 2'd0, "malformed failure result")

   // no request is taken while a result is pending
   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "request taken while result pending")

   // a load never produces a result
   `ASSERT_NEXT(a_load_silent, clock, reset, load_xfer, !rsp_valid, "result after a load transfer")

endmodule

bind free_list_bitmap_rebuild_top flbr_checker u_flbr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_command         (req_chan.command),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_ok              (rsp_chan.ok),
   .rsp_allocated_count (rsp_chan.allocated_count),
   .rsp_word_index      (rsp_chan.word_index),
   .rsp_bitmap_word     (rsp_chan.bitmap_word),
   .rsp_last            (rsp_chan.last)
);
